>>> rtl/rrtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtd_pkg: shared types for the round-robin thread dispatcher
// Status codes, slot position record and the control bundle that drives
// the row of slot cells.
// ----------------------------------------------------------------------------
package rrtd_pkg;

  localparam int unsigned DEF_TOTAL_SLOTS      = 16;
  localparam int unsigned DEF_CORES_PER_CPU    = 4;
  localparam int unsigned DEF_THREADS_PER_CORE = 2;

  // widest slot index over the supported range (up to 64 slots)
  localparam int unsigned SLOT_MAX_W   = 6;
  localparam int unsigned CORE_MAX_W   = 4;
  localparam int unsigned THREAD_MAX_W = 3;

  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned REL_W      = 4;
  localparam int unsigned PID_W      = 16;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    STAT_IDLE       = 2'd0,
    STAT_DISPATCHED = 2'd1,
    STAT_NO_SLOT    = 2'd2,
    STAT_EMPTY      = 2'd3
  } status_t;

  typedef enum logic {
    ACT_TICK    = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [SLOT_MAX_W-1:0]   flat;
    logic [SLOT_MAX_W-1:0]   cpu;
    logic [CORE_MAX_W-1:0]   core;
    logic [THREAD_MAX_W-1:0] thread;
  } slot_pos_t;

  typedef struct packed {
    logic                  scan;
    logic                  load;
    logic [SLOT_MAX_W-1:0] start_slot;
    logic                  rel_en;
    logic [REL_W-1:0]      rel_slot;
  } cell_ctrl_t;

  // step to the next slot, keeping cpu / core / thread in step with it
  function automatic slot_pos_t pos_advance(slot_pos_t p, int total, int cores, int threads);
    slot_pos_t n;
    n = p;
    if (int'(p.flat) == total - 1) begin
      n = '0;
    end else begin
      n.flat = p.flat + 6'd1;
      if (int'(p.thread) == threads - 1) begin
        n.thread = '0;
        if (int'(p.core) == cores - 1) begin
          n.core = '0;
          n.cpu  = p.cpu + 6'd1;
        end else begin
          n.core = p.core + 4'd1;
        end
      end else begin
        n.thread = p.thread + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/rrtd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtd_cell: one hardware thread slot
// Holds the slot busy flag and one stage of the circulating search token.
// ----------------------------------------------------------------------------
module rrtd_cell
  import rrtd_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       token_in,
  output logic       token_out,
  output logic       hit
);

  logic busy;
  logic token;

  assign hit       = ctrl.scan && token && !busy;
  assign token_out = token;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      token <= 1'b0;
    end else begin
      if (hit) begin
        busy <= 1'b1;
      end else if (ctrl.rel_en &&
                   ({{(SLOT_MAX_W-REL_W){1'b0}}, ctrl.rel_slot} == SLOT_MAX_W'(IDX))) begin
        busy <= 1'b0;
      end
      if (ctrl.load) begin
        token <= (ctrl.start_slot == SLOT_MAX_W'(IDX));
      end else if (ctrl.scan) begin
        token <= token_in;
      end
    end
  end

endmodule

>>> rtl/round_robin_thread_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_dispatcher: interval timer and round-robin slot grant
// Counts tick requests and, at each interval, grants the ready queue head
// to the next free hardware thread slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request: tuser = action (0 tick, 1 release), tdata holds
//   release_slot, queue_nonempty, head_pid and head_table_base. Every request
//   yields exactly one response on m_*: tuser = status, tdata = slot fields
//   and the granted pid / page-table base.
//   cfg_we / cfg_wdata write the dispatch interval; write it only while idle.
//   Release and non-dispatching tick requests finish in the accept cycle; their
//   response passes through the holding register into the output register,
//   which raises m_tvalid. A dispatching tick circulates a search token along
//   the ring of slot cells, one slot per cycle, until a free slot is hit or
//   the whole ring has been walked; no request is taken while a scan runs.
//   A finished response waits in a holding register while the output register
//   is stalled by m_tready, so one further request can still be taken.
//   Reset frees all slots, clears the tick count and search start, and sets
//   the interval to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_thread_dispatcher
  import rrtd_pkg::*;
#(
  parameter int unsigned TOTAL_SLOTS      = DEF_TOTAL_SLOTS,
  parameter int unsigned CORES_PER_CPU    = DEF_CORES_PER_CPU,
  parameter int unsigned THREADS_PER_CORE = DEF_THREADS_PER_CORE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [INTERVAL_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // release_slot[3:0], queue_nonempty[4], head_pid[20:5], head_table_base[52:21]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action[0]
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // flat_slot[3:0], cpu_number[4], core_number[6:5], thread_number[7],
  // granted_pid[23:8], granted_table_base[55:24]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]            m_tuser
);

  localparam int unsigned STEP_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  state_t                state, state_next;
  logic [INTERVAL_W-1:0] dispatch_interval;
  logic [INTERVAL_W-1:0] tick_count;
  logic [INTERVAL_W-1:0] tick_next;
  slot_pos_t             search_start;
  slot_pos_t             pos;
  logic [STEP_W-1:0]     step;
  logic [PID_W-1:0]      pid;
  logic [BASE_W-1:0]     base;

  logic                  res_valid;
  status_t               res_status;
  logic [OUT_DATA_W-1:0] res_data;

  cell_ctrl_t            ctrl;
  logic [TOTAL_SLOTS-1:0] token_vec;
  logic [TOTAL_SLOTS-1:0] hit_vec;

  logic       accept, is_release, fire, start_scan, any_hit, last_step, scan_done, load_out;
  logic       in_nonempty;
  logic [REL_W-1:0] in_rel;

  assign in_rel      = s_tdata[3:0];
  assign in_nonempty = s_tdata[4];

  assign accept     = s_tvalid && s_tready;
  assign is_release = (action_t'(s_tuser[0]) == ACT_RELEASE);
  assign tick_next  = tick_count + 16'd1;
  assign fire       = accept && !is_release && (tick_next == dispatch_interval);
  assign start_scan = fire && in_nonempty;
  assign any_hit    = |hit_vec;
  assign last_step  = (step == STEP_W'(TOTAL_SLOTS - 1));
  assign scan_done  = (state == S_SCAN) && (any_hit || last_step);
  assign load_out   = res_valid && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start_scan) state_next = S_SCAN;
      S_SCAN: if (scan_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_tready        = (state == S_IDLE) && (!res_valid || load_out);
    ctrl.scan       = (state == S_SCAN);
    ctrl.load       = start_scan;
    ctrl.start_slot = search_start.flat;
    ctrl.rel_en     = accept && is_release;
    ctrl.rel_slot   = in_rel;
  end

  // ring of slot cells, token moves one slot per cycle while scanning
  for (genvar i = 0; i < TOTAL_SLOTS; i++) begin : g_cell
    rrtd_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .token_in (token_vec[(i + TOTAL_SLOTS - 1) % TOTAL_SLOTS]),
      .token_out(token_vec[i]),
      .hit      (hit_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      dispatch_interval <= 16'd1;
      tick_count        <= '0;
      search_start      <= '0;
      res_valid         <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        dispatch_interval <= cfg_wdata;
      end
      if (accept && !is_release) begin
        tick_count <= fire ? '0 : tick_next;
      end
      if (scan_done && any_hit) begin
        search_start <= pos_advance(pos, TOTAL_SLOTS, CORES_PER_CPU, THREADS_PER_CORE);
      end
      if ((accept && !start_scan) || scan_done) begin
        res_valid <= 1'b1;
      end else if (load_out) begin
        res_valid <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // scan position, request payload and result registers
  always_ff @(posedge clk) begin
    if (start_scan) begin
      pos  <= search_start;
      step <= '0;
      pid  <= s_tdata[20:5];
      base <= s_tdata[52:21];
    end else if (state == S_SCAN) begin
      pos  <= pos_advance(pos, TOTAL_SLOTS, CORES_PER_CPU, THREADS_PER_CORE);
      step <= step + 1'b1;
    end
    if (accept && !start_scan) begin
      res_status <= fire ? STAT_EMPTY : STAT_IDLE;
      res_data   <= '0;
    end else if (scan_done) begin
      if (any_hit) begin
        res_status <= STAT_DISPATCHED;
        res_data   <= {base, pid, pos.thread[0], pos.core[1:0], pos.cpu[0], pos.flat[3:0]};
      end else begin
        res_status <= STAT_NO_SLOT;
        res_data   <= '0;
      end
    end
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= res_data;
    end
  end

`ifndef SYNTH
  a_one_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one slot cell granted in one cycle");

  a_hit_only_scan: assert property (@(posedge clk) disable iff (rst)
    any_hit |-> state == S_SCAN)
    else $error("slot grant outside a scan");

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> $onehot(token_vec))
    else $error("search token lost or duplicated during scan");

  a_no_accept_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !s_tready)
    else $error("request accepted while a scan is running");

  a_res_kept: assert property (@(posedge clk) disable iff (rst)
    res_valid && m_tvalid && !m_tready |=> res_valid)
    else $error("held response dropped while output stalled");
`endif

endmodule
